// File: rtl/bmpp_pkg.sv
// ----------------------------------------------------------------------------
// BMP pixel parser package
// Shared constants, parse phase and channel types and the staged byte record.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpp_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 4096;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned HDR_IDX_W  = 6;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = HDR_IDX_W'(14 + 40 - 1);
    localparam logic [HDR_IDX_W-1:0] WIDTH_AT  = HDR_IDX_W'(18);
    localparam logic [HDR_IDX_W-1:0] HEIGHT_AT = HDR_IDX_W'(22);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CH_BLUE,
        CH_GREEN,
        CH_RED
    } channel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_file;
    } in_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_stage_t;

endpackage

`default_nettype wire

// File: rtl/bmpp_in_if.sv
// ----------------------------------------------------------------------------
// BMP byte stream channel
// Valid/ready channel that carries one raw file byte and its start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/bmpp_out_if.sv
// ----------------------------------------------------------------------------
// BMP pixel result channel
// Valid/ready channel that carries one pixel with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output column, output row, output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input column, input row, input last_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/bmpp_in_stage.sv
// ----------------------------------------------------------------------------
// BMP parser input stage
// Registers each incoming byte; advances whenever the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpp_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    bmpp_in_if.sink                  in_ch,
    input  wire logic                take_ready,
    output bmpp_pkg::in_stage_t      stage
);
    import bmpp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ch.ready = !valid_reg || take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.data_byte     <= in_ch.data_byte;
            item_reg.start_of_file <= in_ch.start_of_file;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/bmpp_parser.sv
// ----------------------------------------------------------------------------
// BMP parser core
// Header count, dimension capture, pixel assembly, row padding skip and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpp_parser #(
    parameter int unsigned MAX_DIM = bmpp_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bmpp_pkg::in_stage_t stage,
    output logic                     take_ready,
    bmpp_out_if.source               out_ch
);
    import bmpp_pkg::*;

    localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
    localparam int unsigned COUNT_W = (DIM_W > POS_W) ? DIM_W : POS_W;

    phase_t               phase_reg,   phase_next;
    logic [HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic [DIM_W-1:0]     width_reg,   width_next;
    logic [DIM_W-1:0]     height_reg,  height_next;
    channel_t             chan_reg,    chan_next;
    logic [BYTE_W-1:0]    blue_reg,    blue_next;
    logic [BYTE_W-1:0]    green_reg,   green_next;
    logic [COUNT_W-1:0]   col_reg,     col_next;
    logic [COUNT_W-1:0]   row_reg,     row_next;
    logic [1:0]           pad_reg,     pad_next;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    red_reg;
    logic [BYTE_W-1:0]    green_out_reg;
    logic [BYTE_W-1:0]    blue_out_reg;
    logic [POS_W-1:0]     column_reg;
    logic [POS_W-1:0]     row_out_reg;
    logic                 last_reg;

    logic                 take;
    logic                 emit;
    logic                 last;
    logic                 row_end;
    logic [BYTE_W-1:0]    b;
    logic [1:0]           lane;
    logic [31:0]          term;
    logic [31:0]          sum;

    assign take_ready = !out_valid_reg || out_ch.ready;
    assign take       = stage.valid && take_ready;
    assign b          = stage.item.data_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        chan_next    = chan_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        emit         = 1'b0;
        last         = 1'b0;
        row_end      = 1'b0;
        lane         = 2'd0;
        term         = 32'd0;
        sum          = 32'd0;

        if (stage.item.start_of_file)
        begin
            phase_next   = PH_HEADER;
            hdr_idx_next = '0;
            width_next   = '0;
            height_next  = '0;
            chan_next    = CH_BLUE;
            blue_next    = '0;
            green_next   = '0;
            col_next     = '0;
            row_next     = '0;
            pad_next     = '0;
        end

        unique case (phase_next)
            PH_HEADER:
            begin
                if (hdr_idx_next >= WIDTH_AT && hdr_idx_next < WIDTH_AT + HDR_IDX_W'(4))
                begin
                    lane       = 2'(hdr_idx_next - WIDTH_AT);
                    term       = 32'(b) << {lane, 3'b000};
                    sum        = 32'(width_next) + term;
                    width_next = (sum > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sum[DIM_W-1:0];
                end
                else if (hdr_idx_next >= HEIGHT_AT &&
                         hdr_idx_next < HEIGHT_AT + HDR_IDX_W'(4))
                begin
                    lane        = 2'(hdr_idx_next - HEIGHT_AT);
                    term        = 32'(b) << {lane, 3'b000};
                    sum         = 32'(height_next) + term;
                    height_next = (sum > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sum[DIM_W-1:0];
                end
                if (hdr_idx_next >= HDR_LAST)
                begin
                    hdr_idx_next = '0;
                    chan_next    = CH_BLUE;
                    col_next     = '0;
                    row_next     = '0;
                    phase_next   = (width_next == '0 || height_next == '0) ? PH_DONE
                                                                            : PH_PIXEL;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_next + HDR_IDX_W'(1);
                end
            end
            PH_PAD:
            begin
                if (pad_next != 2'd0)
                begin
                    pad_next = pad_next - 2'd1;
                end
                if (pad_next == 2'd0)
                begin
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL:
            begin
                case (chan_next)
                    CH_BLUE:
                    begin
                        blue_next = b;
                        chan_next = CH_GREEN;
                    end
                    CH_GREEN:
                    begin
                        green_next = b;
                        chan_next  = CH_RED;
                    end
                    default:
                    begin
                        chan_next = CH_BLUE;
                        emit      = 1'b1;
                        row_end   = ({1'b0, col_next} + (COUNT_W+1)'(1)) >=
                                    (COUNT_W+1)'(width_next);
                        last      = row_end &&
                                    (({1'b0, row_next} + (COUNT_W+1)'(1)) >=
                                     (COUNT_W+1)'(height_next));
                        if (last)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (row_end)
                        begin
                            col_next = '0;
                            row_next = row_next + COUNT_W'(1);
                            if (2'(width_next) != 2'd0)
                            begin
                                pad_next   = 2'(width_next);
                                phase_next = PH_PAD;
                            end
                        end
                        else
                        begin
                            col_next = col_next + COUNT_W'(1);
                        end
                    end
                endcase
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            chan_reg    <= CH_BLUE;
            blue_reg    <= '0;
            green_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            chan_reg    <= chan_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take_ready)
        begin
            out_valid_reg <= take && emit;
        end
    end

    // hold the result until the downstream transfer
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            red_reg       <= b;
            green_out_reg <= green_reg;
            blue_out_reg  <= blue_reg;
            column_reg    <= col_reg[POS_W-1:0];
            row_out_reg   <= row_reg[POS_W-1:0];
            last_reg      <= last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.red        = red_reg;
    assign out_ch.green      = green_out_reg;
    assign out_ch.blue       = blue_out_reg;
    assign out_ch.column     = column_reg;
    assign out_ch.row        = row_out_reg;
    assign out_ch.last_pixel = last_reg;

`ifndef SYNTHESIS
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg == CH_BLUE || chan_reg == CH_GREEN || chan_reg == CH_RED)
        else $error("channel index out of range");

    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("padding phase with no padding left");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && last) |=> phase_reg == PH_DONE)
        else $error("last pixel did not end the image");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXEL |-> (COUNT_W+1)'(col_reg) < (COUNT_W+1)'(width_reg))
        else $error("column beyond image width");
`endif

endmodule

`default_nettype wire

// File: rtl/bmp_rgb24_pixel_parser.sv
// ----------------------------------------------------------------------------
// 24-bit BMP pixel parser
// Path: the red byte is held in the input stage register, the pixel in the result register.
// Throughput: one byte per cycle while the result channel does not stall; one pixel per three pixel bytes.
// Reset: rst_n clears all parse state; the next byte is file byte 0.
// start_of_file restarts the parse on the byte that carries it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rgb24_pixel_parser #(
    parameter int unsigned MAX_DIM = bmpp_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmpp_in_if.sink     in_ch,
    bmpp_out_if.source  out_ch
);
    import bmpp_pkg::*;

    in_stage_t stage;
    logic      take_ready;

    bmpp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take_ready (take_ready),
        .stage      (stage)
    );

    bmpp_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .take_ready (take_ready),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
